/* src/wctg_pkg.sv */
// Package: shared constants and word types for the windowed counter gamma tracker.
package wctg_pkg;

    localparam int WINDOW_BITS = 16;
    localparam int TAG_BITS    = 4;
    localparam int COUNT_W     = 31;
    localparam int CTR_W       = 20;
    localparam int EST_W       = 32;
    localparam int FUNC_W      = 2;

    localparam int GAMMAS      = (1 << TAG_BITS) - 1;
    localparam int LOW_BITS    = (WINDOW_BITS > TAG_BITS) ? (WINDOW_BITS - TAG_BITS) : 0;
    localparam int HI_W        = COUNT_W - LOW_BITS;
    localparam int BOUND_W     = COUNT_W + 1;

    // one window span added to the rounded-down maximum in the query
    localparam logic [BOUND_W-1:0] WINDOW_SPAN = BOUND_W'(64'd1 << WINDOW_BITS);

    localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [COUNT_W-1:0]  value;
        logic [TAG_BITS-1:0] gamma_select;
    } t_in_word;

    typedef struct packed {
        logic                found;
        logic [TAG_BITS-1:0] min_gamma;
        logic [EST_W-1:0]    estimate;
    } t_out_word;

endpackage

/* src/wctg_lane.sv */
// Lane: one gamma tracker, running maximum and high counter with their update logic.
module wctg_lane (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_update,
    input  logic [wctg_pkg::COUNT_W-1:0]       i_count,
    input  logic [wctg_pkg::TAG_BITS-1:0]      i_gamma,
    output logic                               o_hit,
    output logic [wctg_pkg::EST_W-1:0]         o_estimate
);

    logic [wctg_pkg::COUNT_W-1:0]  r_max;
    logic [wctg_pkg::COUNT_W-1:0]  n_max;
    logic [wctg_pkg::CTR_W-1:0]    r_ctr;
    logic [wctg_pkg::CTR_W-1:0]    n_ctr;

    logic [wctg_pkg::HI_W-1:0]     w_hi_new;
    logic [wctg_pkg::HI_W-1:0]     w_hi_diff;
    logic [wctg_pkg::TAG_BITS-1:0] w_step;
    logic [wctg_pkg::COUNT_W-1:0]  w_max_floor;
    logic [wctg_pkg::BOUND_W-1:0]  w_bound;

    assign w_hi_new  = i_count[wctg_pkg::COUNT_W-1:wctg_pkg::LOW_BITS];
    // count > max guarantees the high parts do not go backward
    assign w_hi_diff = w_hi_new - r_max[wctg_pkg::COUNT_W-1:wctg_pkg::LOW_BITS];
    assign w_step    = w_hi_new[wctg_pkg::TAG_BITS-1:0] - r_ctr[wctg_pkg::TAG_BITS-1:0];

    always_comb begin
        n_max = r_max;
        n_ctr = r_ctr;
        if (i_update) begin
            if ((i_count > r_max) && (w_hi_diff <= wctg_pkg::HI_W'(i_gamma))) begin
                n_max = i_count;
            end
            if (w_step <= i_gamma) begin
                n_ctr = r_ctr + wctg_pkg::CTR_W'(w_step);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= '0;
            r_ctr <= '0;
        end else begin
            r_max <= n_max;
            r_ctr <= n_ctr;
        end
    end

    // query bound: maximum rounded down to the low-part grid, plus one window
    assign w_max_floor = {r_max[wctg_pkg::COUNT_W-1:wctg_pkg::LOW_BITS],
                          {wctg_pkg::LOW_BITS{1'b0}}};
    assign w_bound     = wctg_pkg::BOUND_W'(w_max_floor) + wctg_pkg::WINDOW_SPAN;
    assign o_hit       = w_bound > wctg_pkg::BOUND_W'(i_count);

    assign o_estimate  = wctg_pkg::EST_W'({r_ctr, {wctg_pkg::LOW_BITS{1'b0}}});

endmodule

/* src/windowed_counter_gamma_tracker_core.sv */
// Top level: input register, bank of gamma lanes, query pick and result register.
// A query or read result is registered into the result stage when its word leaves the input register.
// Throughput: one word per cycle while o_stall is low; all fifteen lanes update in parallel. A result held by
// i_stall keeps the next query or read word in the input register, which then stalls the input.
// Updates and unknown function codes produce no result word.
// Reset (i_rst_n low, synchronous) clears both valid flags and zeroes every lane.
module windowed_counter_gamma_tracker_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  wctg_pkg::t_in_word  i_word,
    output logic                o_valid,
    input  logic                i_stall,
    output wctg_pkg::t_out_word o_word
);

    // input stage
    logic                r_in_valid;
    logic                n_in_valid;
    wctg_pkg::t_in_word  r_in;

    // result stage
    logic                r_out_valid;
    logic                n_out_valid;
    wctg_pkg::t_out_word r_out;
    wctg_pkg::t_out_word n_out;

    logic w_accept;
    logic w_has_result;
    logic w_advance;
    logic w_update;

    logic [wctg_pkg::GAMMAS-1:0] w_hit;
    logic [wctg_pkg::EST_W-1:0]  w_est [wctg_pkg::GAMMAS];

    logic                          w_found;
    logic [wctg_pkg::TAG_BITS-1:0] w_min_gamma;
    logic [wctg_pkg::EST_W-1:0]    w_estimate;

    // only query and read words give a result; they wait for room downstream
    assign w_has_result = (r_in.func == wctg_pkg::FUNC_QUERY) ||
                          (r_in.func == wctg_pkg::FUNC_READ);
    assign w_advance    = r_in_valid && (!w_has_result || !r_out_valid || !i_stall);
    assign o_stall      = r_in_valid && !w_advance;
    assign w_accept     = i_valid && !o_stall;
    assign w_update     = w_advance && (r_in.func == wctg_pkg::FUNC_UPDATE);

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_accept) begin
            n_in_valid = 1'b1;
        end else if (w_advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_word;
        end
    end

    // lane bank: each lane sees the registered value as count or query size
    for (genvar g = 0; g < wctg_pkg::GAMMAS; g++) begin : g_lane
        wctg_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_update   (w_update),
            .i_count    (r_in.value),
            .i_gamma    (wctg_pkg::TAG_BITS'(g + 1)),
            .o_hit      (w_hit[g]),
            .o_estimate (w_est[g])
        );
    end

    // smallest gamma that satisfies the query: scan from the top down
    always_comb begin
        w_found     = 1'b0;
        w_min_gamma = '0;
        for (int g = wctg_pkg::GAMMAS - 1; g >= 0; g--) begin
            if (w_hit[g]) begin
                w_found     = 1'b1;
                w_min_gamma = wctg_pkg::TAG_BITS'(g + 1);
            end
        end
    end

    // gamma_select of zero names no lane
    always_comb begin
        w_estimate = '0;
        for (int g = 0; g < wctg_pkg::GAMMAS; g++) begin
            if (r_in.gamma_select == wctg_pkg::TAG_BITS'(g + 1)) begin
                w_estimate = w_est[g];
            end
        end
    end

    always_comb begin
        n_out = '0;
        if (r_in.func == wctg_pkg::FUNC_QUERY) begin
            n_out.found     = w_found;
            n_out.min_gamma = w_min_gamma;
        end else begin
            n_out.estimate  = w_estimate;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_advance && w_has_result) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_has_result) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

    // a held input word is never overwritten by a new one
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> (!r_in_valid || w_advance))
        else $error("input word overwritten");

    // a word that could not advance is still held next cycle
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> r_in_valid)
        else $error("held input word lost");

    // a query result carries no estimate
    a_found_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_word.found) |-> (o_word.estimate == '0))
        else $error("query result with estimate");

    // no gamma found means min_gamma is zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_word.found) |-> (o_word.min_gamma == '0))
        else $error("min_gamma set without found");

    // a result taken downstream is not shown again unless a new one was loaded
    a_no_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !(w_advance && w_has_result)) |=> !o_valid)
        else $error("result word repeated");

endmodule

/* dv/windowed_counter_gamma_tracker_core_tb.sv */
// Testbench for windowed_counter_gamma_tracker_core: predicts every result word and checks it.
module windowed_counter_gamma_tracker_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Function code 3 has no name in the package; the core must drop it silently.
    localparam logic [wctg_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam logic [63:0] COUNT_MAX   = (64'd1 << wctg_pkg::COUNT_W) - 1;
    localparam logic [63:0] LOW_MASK    = (64'd1 << wctg_pkg::LOW_BITS) - 1;
    localparam logic [63:0] TAG_MASK    = 64'(wctg_pkg::GAMMAS);
    localparam int          CYCLE_LIMIT = 200_000;
    localparam int          TAIL_CYCLES = 8;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    wctg_pkg::t_in_word  i_word;
    logic                o_valid;
    logic                i_stall;
    wctg_pkg::t_out_word o_word;

    windowed_counter_gamma_tracker_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_word  (i_word),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (o_word)
    );

    // Predicted lane state, indexed by gamma (1 .. GAMMAS).
    logic [wctg_pkg::COUNT_W-1:0] lane_maximum [1:wctg_pkg::GAMMAS];
    logic [wctg_pkg::CTR_W-1:0]   lane_high_ctr[1:wctg_pkg::GAMMAS];

    // Result words still owed by the core, oldest first.
    wctg_pkg::t_out_word pending_results[$];

    int  error_count;
    int  cycle_count;
    int  updates_sent;
    int  queries_sent;
    int  reads_sent;
    int  ignored_sent;
    int  results_checked;
    int  input_stall_cycles;

    bit  idle_on;        // both sides insert random gaps when set
    int  hold_request;   // receiver picks this up as the length of its next stall

    // Running observed count used to build well-formed update streams.
    logic [wctg_pkg::COUNT_W-1:0] stream_count;

    // ------------------------------------------------------------------
    // Clock and cycle guard
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still pending",
                     cycle_count, pending_results.size());
            $display("windowed_counter_gamma_tracker_core regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void clear_lanes();
        for (int g = 1; g <= wctg_pkg::GAMMAS; g++) begin
            lane_maximum[g]  = '0;
            lane_high_ctr[g] = '0;
        end
    endfunction

    // An update word: every lane decides independently from its old state.
    function automatic void track_count(logic [wctg_pkg::COUNT_W-1:0] cnt);
        logic [63:0] hi_new;
        logic [63:0] mid;
        logic [63:0] cur_hi;
        logic [63:0] step;
        hi_new = 64'(cnt) >> wctg_pkg::LOW_BITS;
        mid    = hi_new & TAG_MASK;
        for (int g = 1; g <= wctg_pkg::GAMMAS; g++) begin
            cur_hi = 64'(lane_maximum[g]) >> wctg_pkg::LOW_BITS;
            // the maximum only moves forward, and by at most gamma high-part steps
            if (cnt > lane_maximum[g] && (hi_new - cur_hi) <= 64'(g))
                lane_maximum[g] = cnt;
            // forward tag distance, mod 2^TAG_BITS
            step = (mid - (64'(lane_high_ctr[g]) & TAG_MASK)) & TAG_MASK;
            if (step <= 64'(g))
                lane_high_ctr[g] = wctg_pkg::CTR_W'(64'(lane_high_ctr[g]) + step);
        end
    endfunction

    // Smallest gamma whose rounded maximum plus one window exceeds the size.
    function automatic wctg_pkg::t_out_word min_gamma_for(logic [wctg_pkg::COUNT_W-1:0] size);
        wctg_pkg::t_out_word r;
        logic [63:0] bound;
        r = '0;
        for (int g = 1; g <= wctg_pkg::GAMMAS; g++) begin
            bound = (64'(lane_maximum[g]) & ~LOW_MASK) + (64'd1 << wctg_pkg::WINDOW_BITS);
            if (bound > 64'(size)) begin
                r.found     = 1'b1;
                r.min_gamma = wctg_pkg::TAG_BITS'(g);
                return r;
            end
        end
        return r;
    endfunction

    function automatic wctg_pkg::t_out_word estimate_for(logic [wctg_pkg::TAG_BITS-1:0] sel);
        wctg_pkg::t_out_word r;
        r = '0;
        if (sel >= 1 && sel <= wctg_pkg::GAMMAS)
            r.estimate = wctg_pkg::EST_W'(64'(lane_high_ctr[sel]) << wctg_pkg::LOW_BITS);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting and result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH cycle %0d: %s got 0x%0h expected 0x%0h",
                 cycle_count, what, got, want);
        error_count++;
    endtask

    // Output side is sampled at the rising edge; a word moves when valid and not stalled.
    always @(posedge i_clk) begin
        wctg_pkg::t_out_word want;
        if (i_rst_n && i_valid && o_stall)
            input_stall_cycles++;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result word with nothing pending", 64'(o_word), 64'd0);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (o_word.found !== want.found)
                    report_mismatch("found", 64'(o_word.found), 64'(want.found));
                if (o_word.min_gamma !== want.min_gamma)
                    report_mismatch("min_gamma", 64'(o_word.min_gamma), 64'(want.min_gamma));
                if (o_word.estimate !== want.estimate)
                    report_mismatch("estimate", 64'(o_word.estimate), 64'(want.estimate));
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall per result word, plus long holds on request
    // ------------------------------------------------------------------
    initial begin
        int n;
        i_stall = 1'b0;
        forever begin
            if (hold_request > 0) begin
                n = hold_request;
                hold_request = 0;
            end else begin
                n = idle_on ? $urandom_range(0, 10) : 0;
            end
            repeat (n) begin
                @(negedge i_clk);
                i_stall = 1'b1;
            end
            @(negedge i_clk);
            i_stall = 1'b0;
            // wait for the word to move, or for a hold to start
            do @(posedge i_clk); while (!o_valid && hold_request == 0);
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    // Drives one word at the falling edge and holds it until accepted.
    // Valid stays high afterwards so the next word can follow back to back.
    task automatic send_word(logic [wctg_pkg::FUNC_W-1:0] f,
                             logic [wctg_pkg::COUNT_W-1:0] v,
                             logic [wctg_pkg::TAG_BITS-1:0] sel);
        wctg_pkg::t_in_word w;
        int gap;
        w.func         = f;
        w.value        = v;
        w.gamma_select = sel;
        gap = idle_on ? $urandom_range(0, 10) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_word  = w;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        case (f)
            wctg_pkg::FUNC_UPDATE: begin
                track_count(v);
                updates_sent++;
            end
            wctg_pkg::FUNC_QUERY: begin
                pending_results.push_back(min_gamma_for(v));
                queries_sent++;
            end
            wctg_pkg::FUNC_READ: begin
                pending_results.push_back(estimate_for(sel));
                reads_sent++;
            end
            default: begin
                ignored_sent++;
            end
        endcase
    endtask

    task automatic go_quiet();
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic wait_for_results(int max_cycles);
        int waited;
        waited = 0;
        while (pending_results.size() != 0 && waited < max_cycles) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_corners();
        // empty bank: every maximum is zero, so bound is one window
        send_word(wctg_pkg::FUNC_UPDATE, '0, '0);
        send_word(wctg_pkg::FUNC_QUERY, '0, '0);
        send_word(wctg_pkg::FUNC_QUERY, wctg_pkg::COUNT_W'(COUNT_MAX), 4'hF);
        send_word(wctg_pkg::FUNC_QUERY,
                  wctg_pkg::COUNT_W'((64'd1 << wctg_pkg::WINDOW_BITS) - 1), '0);
        send_word(wctg_pkg::FUNC_QUERY,
                  wctg_pkg::COUNT_W'(64'd1 << wctg_pkg::WINDOW_BITS), '0);
        // largest count: too far ahead for any maximum, tag distance 15 reaches the top lane
        send_word(wctg_pkg::FUNC_UPDATE, wctg_pkg::COUNT_W'(COUNT_MAX), '0);
        send_word(wctg_pkg::FUNC_READ, '0, 4'd15);
        send_word(wctg_pkg::FUNC_READ, '0, 4'd14);
        send_word(wctg_pkg::FUNC_READ, wctg_pkg::COUNT_W'(COUNT_MAX), 4'd0);
        // three high-part steps ahead: only lanes with gamma of three or more take it
        send_word(wctg_pkg::FUNC_UPDATE,
                  wctg_pkg::COUNT_W'((64'd3 << wctg_pkg::LOW_BITS) | 64'd5), '0);
        send_word(wctg_pkg::FUNC_QUERY,
                  wctg_pkg::COUNT_W'((64'd3 << wctg_pkg::LOW_BITS)
                                     + (64'd1 << wctg_pkg::WINDOW_BITS) - 1), '0);
        send_word(wctg_pkg::FUNC_QUERY,
                  wctg_pkg::COUNT_W'((64'd3 << wctg_pkg::LOW_BITS)
                                     + (64'd1 << wctg_pkg::WINDOW_BITS)), '0);
        send_word(wctg_pkg::FUNC_READ, '0, 4'd1);
        send_word(wctg_pkg::FUNC_READ, '0, 4'd3);
        send_word(wctg_pkg::FUNC_READ, '0, 4'd15);
        // unknown function code: no word back, no state change
        send_word(FUNC_UNUSED, wctg_pkg::COUNT_W'(COUNT_MAX), 4'hF);
        send_word(FUNC_UNUSED, '0, '0);
        send_word(wctg_pkg::FUNC_READ, '0, 4'd15);
        // smaller count: maxima hold, but tag wraps backward and counters move
        send_word(wctg_pkg::FUNC_UPDATE, wctg_pkg::COUNT_W'(5), 4'hA);
        send_word(wctg_pkg::FUNC_READ, '0, 4'd13);
        send_word(wctg_pkg::FUNC_READ, '0, 4'd12);
        send_word(wctg_pkg::FUNC_QUERY,
                  wctg_pkg::COUNT_W'((64'd3 << wctg_pkg::LOW_BITS)
                                     + (64'd1 << wctg_pkg::WINDOW_BITS) - 1), '0);
    endtask

    // Mostly well-formed streams of slowly advancing counts, with queries near
    // the lanes' bounds; a small share is random noise and ignored codes.
    task automatic test_random_tracking(int n_words);
        int pick;
        int g;
        logic [63:0] wide;
        logic [63:0] back;
        for (int k = 0; k < n_words; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                if ($urandom_range(0, 19) == 0)
                    stream_count = lane_maximum[$urandom_range(1, wctg_pkg::GAMMAS)];
                else if ($urandom_range(0, 39) == 0)
                    stream_count = wctg_pkg::COUNT_W'($urandom);
                if ($urandom_range(0, 9) == 0) begin
                    back = 64'($urandom_range(0, 3)) << wctg_pkg::LOW_BITS;
                    wide = (64'(stream_count) > back) ? 64'(stream_count) - back : 64'd0;
                end else begin
                    wide = 64'(stream_count)
                         + (64'($urandom_range(0, 18)) << wctg_pkg::LOW_BITS)
                         + 64'($urandom_range(0, int'(LOW_MASK)));
                end
                if (wide > COUNT_MAX)
                    wide = 64'($urandom_range(0, 1 << 20));
                stream_count = wctg_pkg::COUNT_W'(wide);
                send_word(wctg_pkg::FUNC_UPDATE, stream_count, wctg_pkg::TAG_BITS'($urandom));
            end else if (pick < 72) begin
                g = $urandom_range(1, wctg_pkg::GAMMAS);
                case ($urandom_range(0, 3))
                    0: wide = 64'($urandom) & COUNT_MAX;
                    1: wide = 64'($urandom_range(0, 1 << 17));
                    default: begin
                        // straddle one lane's bound by a couple of counts
                        wide = (64'(lane_maximum[g]) & ~LOW_MASK)
                             + (64'd1 << wctg_pkg::WINDOW_BITS)
                             + 64'($urandom_range(0, 3)) - 64'd2;
                        if (wide > COUNT_MAX)
                            wide = COUNT_MAX;
                    end
                endcase
                send_word(wctg_pkg::FUNC_QUERY, wctg_pkg::COUNT_W'(wide),
                          wctg_pkg::TAG_BITS'($urandom));
            end else if (pick < 90) begin
                send_word(wctg_pkg::FUNC_READ, wctg_pkg::COUNT_W'($urandom),
                          wctg_pkg::TAG_BITS'($urandom_range(0, 15)));
            end else if (pick < 95) begin
                send_word(wctg_pkg::FUNC_UPDATE, wctg_pkg::COUNT_W'($urandom),
                          wctg_pkg::TAG_BITS'($urandom));
            end else begin
                send_word(FUNC_UNUSED, wctg_pkg::COUNT_W'($urandom),
                          wctg_pkg::TAG_BITS'($urandom));
            end
        end
    endtask

    // Receiver holds off while the sender keeps offering result-producing
    // words back to back, so the core fills and stalls its input.
    task automatic test_output_hold();
        idle_on = 1'b0;
        hold_request = 80;
        for (int k = 0; k < 40; k++) begin
            if (k % 3 == 0)
                send_word(wctg_pkg::FUNC_QUERY, wctg_pkg::COUNT_W'($urandom),
                          wctg_pkg::TAG_BITS'($urandom));
            else
                send_word(wctg_pkg::FUNC_READ, '0,
                          wctg_pkg::TAG_BITS'($urandom_range(0, 15)));
        end
        idle_on = 1'b1;
    endtask

    // Sender stops until every owed word is out, then resumes.
    task automatic test_pause_until_drained();
        test_random_tracking(20);
        go_quiet();
        wait_for_results(5000);
        test_random_tracking(20);
    endtask

    task automatic test_no_idle_stretch();
        idle_on = 1'b0;
        test_random_tracking(80);
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_word       = '0;
        idle_on      = 1'b1;
        hold_request = 0;
        stream_count = '0;
        clear_lanes();
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_corners();
        test_random_tracking(430);
        test_output_hold();
        test_pause_until_drained();
        test_no_idle_stretch();
        test_random_tracking(440);

        go_quiet();
        wait_for_results(5000);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("words never delivered", 64'(pending_results.size()), 64'd0);

        $display("covered %0d updates, %0d min-gamma queries, %0d estimate reads, %0d ignored",
                 updates_sent, queries_sent, reads_sent, ignored_sent);
        $display("%0d result words checked, input held off %0d cycles, %0d errors",
                 results_checked, input_stall_cycles, error_count);
        if (error_count == 0)
            $display("windowed_counter_gamma_tracker_core regression: pass");
        else
            $display("windowed_counter_gamma_tracker_core regression: fail");
        $finish;
    end

endmodule

/* files.f */
src/wctg_pkg.sv
src/wctg_lane.sv
src/windowed_counter_gamma_tracker_core.sv
dv/windowed_counter_gamma_tracker_core_tb.sv
